/* design/bdma_pkg.sv */
// shared types and constants for the bus dma channel register block
package bdma_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    R_STAG = 3'd0,
    R_STAR = 3'd1,
    R_LEN  = 3'd2,
    R_DIR  = 3'd3,
    R_TSEL = 3'd4,
    R_EN   = 3'd5,
    R_ST   = 3'd6,
    R_SUSP = 3'd7
  } reg_t;

  localparam logic [31:0] ADDR_MASK   = 32'h1FFF_FFE0;
  localparam logic [31:0] ID_VALUE    = 32'h0000_0012;
  localparam logic [5:0]  ID_WORD     = 6'd32;
  localparam logic [5:0]  GEN_BASE    = 6'd33;
  localparam int          GEN_WORDS   = 31;
  localparam int          MAX_CHAN    = 4;
  localparam int          FAST_LIMIT  = 512;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  reg_offset;
    logic [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [3:0]  done_irq_mask;
    logic        error_irq;
    logic        xfer_valid;
    logic [31:0] xfer_source;
    logic [31:0] xfer_target;
    logic [30:0] xfer_length;
  } out_item_t;

  typedef struct packed {
    logic        wr_sel;
    logic        tick;
    reg_t        offs;
    logic [31:0] value;
  } chan_req_t;

  typedef struct packed {
    logic [31:0] rd_word;
    logic        done;
    logic        err;
    logic        xfer_valid;
    logic [31:0] src;
    logic [31:0] dst;
    logic [30:0] len;
  } chan_rsp_t;

endpackage

/* design/bdma_chan.sv */
// one dma channel: its registers, start checks and finish countdown
module bdma_chan import bdma_pkg::*; #(
  parameter int TICKS_PER_BYTE = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  chan_req_t req,
  output chan_rsp_t rsp
);

  localparam int CNT_W = 31 + $clog2(TICKS_PER_BYTE + 1);

  logic [31:0]      stag_r, stag_nxt;
  logic [31:0]      star_r, star_nxt;
  logic             len_hi_r, len_hi_nxt;
  logic [28:0]      len_lo_r, len_lo_nxt;
  logic             dir_r, dir_nxt;
  logic             tsel_r, tsel_nxt;
  logic             en_r, en_nxt;
  logic             st_r, st_nxt;
  logic             stop_r, stop_nxt;
  logic             susp_r, susp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [31:0]      len_word;
  logic [CNT_W-1:0] ticks;
  logic             start_go;
  logic             region_ok;
  logic             launch;
  logic             refuse;
  logic             fast;
  logic             cnt_hit;
  logic             finish;
  logic [31:0]      rd_word;

  assign len_word  = {3'b000, len_lo_r};
  assign ticks     = CNT_W'(len_word) * CNT_W'(TICKS_PER_BYTE);
  assign fast      = ticks <= CNT_W'(FAST_LIMIT);
  assign start_go  = req.wr_sel && (req.offs == R_ST) && req.value[0] && !st_r && en_r;
  assign region_ok = ((star_r[28:26] == 3'd3) || (star_r[28:26] == 3'd1))
                  && ((stag_r[28:26] == 3'd0) || (stag_r[28:26] == 3'd3))
                  && (len_lo_r != '0);
  assign launch    = start_go && region_ok;
  assign refuse    = start_go && !region_ok;
  assign cnt_hit   = req.tick && (cnt_r == CNT_W'(1));
  assign finish    = (launch && fast) || cnt_hit;

  always_comb begin
    stag_nxt   = stag_r;
    star_nxt   = star_r;
    len_hi_nxt = len_hi_r;
    len_lo_nxt = len_lo_r;
    dir_nxt    = dir_r;
    tsel_nxt   = tsel_r;
    en_nxt     = en_r;
    st_nxt     = st_r;
    stop_nxt   = stop_r;
    susp_nxt   = susp_r;
    cnt_nxt    = cnt_r;

    if (req.wr_sel) begin
      unique case (req.offs)
        R_STAG: stag_nxt = req.value & ADDR_MASK;
        R_STAR: star_nxt = req.value & ADDR_MASK;
        R_LEN: begin
          len_hi_nxt = req.value[31];
          len_lo_nxt = req.value[28:0];
        end
        R_DIR:  dir_nxt  = req.value[0];
        R_TSEL: tsel_nxt = req.value[0];
        R_EN:   en_nxt   = req.value[0];
        R_ST:   st_nxt   = st_r;
        R_SUSP: susp_nxt = req.value[0];
      endcase
    end

    if (refuse) begin
      st_nxt = 1'b0;
      en_nxt = 1'b0;
    end
    if (launch) begin
      st_nxt   = 1'b1;
      stop_nxt = 1'b0;
      if (!fast) begin
        cnt_nxt = ticks;
      end
    end
    if (req.tick && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end

    if (finish) begin
      if (len_hi_r) begin
        en_nxt = 1'b0;
      end
      star_nxt   = star_r + len_word;
      stag_nxt   = stag_r + len_word;
      len_hi_nxt = 1'b0;
      len_lo_nxt = '0;
      st_nxt     = 1'b0;
      stop_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stag_r   <= '0;
      star_r   <= '0;
      len_hi_r <= 1'b0;
      len_lo_r <= '0;
      dir_r    <= 1'b0;
      tsel_r   <= 1'b0;
      en_r     <= 1'b0;
      st_r     <= 1'b0;
      stop_r   <= 1'b1;
      susp_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      stag_r   <= stag_nxt;
      star_r   <= star_nxt;
      len_hi_r <= len_hi_nxt;
      len_lo_r <= len_lo_nxt;
      dir_r    <= dir_nxt;
      tsel_r   <= tsel_nxt;
      en_r     <= en_nxt;
      st_r     <= st_nxt;
      stop_r   <= stop_nxt;
      susp_r   <= susp_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_comb begin
    unique case (req.offs)
      R_STAG: rd_word = stag_r;
      R_STAR: rd_word = star_r;
      R_LEN:  rd_word = {len_hi_r, 2'b00, len_lo_r};
      R_DIR:  rd_word = {31'd0, dir_r};
      R_TSEL: rd_word = {31'd0, tsel_r};
      R_EN:   rd_word = {31'd0, en_r};
      R_ST:   rd_word = {31'd0, st_r};
      R_SUSP: rd_word = {27'd0, stop_r, 3'b000, susp_r};
    endcase
  end

  assign rsp.rd_word    = rd_word;
  assign rsp.done       = finish;
  assign rsp.err        = refuse;
  assign rsp.xfer_valid = launch;
  assign rsp.src        = launch ? (dir_r ? stag_r : star_r) : '0;
  assign rsp.dst        = launch ? (dir_r ? star_r : stag_r) : '0;
  assign rsp.len        = launch ? {2'b00, len_lo_r} : '0;

endmodule

/* design/bus_dma_channel_registers.sv */
// top level of the bus dma channel register block
// an accepted item is held in s1_item_r, then its result is registered in out_item_r
// throughput: one item per cycle while out_stall is low, single pass between input and result registers
// a tick that ends a countdown and a short start both finish inside that same item
// reset: synchronous active low; channel registers zero with the stopped bit set,
// countdowns idle, general storage zero, id word fixed
module bus_dma_channel_registers import bdma_pkg::*; #(
  parameter int CHANNELS       = 4,
  parameter int TICKS_PER_BYTE = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic        s1_valid_r, s1_valid_nxt;
  in_item_t    s1_item_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;
  logic [31:0] gen_r [GEN_WORDS];

  logic        move;
  logic        accept;
  logic        fire;
  logic [5:0]  word;
  logic [1:0]  ch_idx;
  logic        in_chan;
  logic        ch_ok;
  logic [4:0]  gen_idx;
  logic [5:0]  gen_diff;
  logic        is_wr;
  logic        gen_wr;

  chan_req_t   req [MAX_CHAN];
  chan_rsp_t   rsp [MAX_CHAN];

  assign move     = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !move;
  assign accept   = in_valid && !in_stall;
  assign fire     = s1_valid_r && move;

  assign word     = s1_item_r.reg_offset[7:2];
  assign ch_idx   = word[4:3];
  assign in_chan  = !word[5];
  assign ch_ok    = {1'b0, ch_idx} < 3'(CHANNELS);
  assign gen_diff = word - GEN_BASE;
  assign gen_idx  = gen_diff[4:0];
  assign is_wr    = fire && (s1_item_r.operation == OP_WRITE);
  assign gen_wr   = is_wr && !in_chan && (word != ID_WORD);

  for (genvar c = 0; c < MAX_CHAN; c++) begin : g_chan
    if (c < CHANNELS) begin : g_live
      assign req[c].wr_sel = is_wr && in_chan && (ch_idx == 2'(c));
      assign req[c].tick   = fire && (s1_item_r.operation == OP_TICK);
      assign req[c].offs   = reg_t'(word[2:0]);
      assign req[c].value  = s1_item_r.write_value;

      bdma_chan #(
        .TICKS_PER_BYTE(TICKS_PER_BYTE)
      ) u_chan (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req[c]),
        .rsp  (rsp[c])
      );
    end else begin : g_absent
      assign req[c] = '0;
      assign rsp[c] = '0;
    end
  end

  always_comb begin
    out_item_nxt = '0;
    unique case (s1_item_r.operation)
      OP_READ: begin
        if (in_chan) begin
          out_item_nxt.read_data = ch_ok ? rsp[ch_idx].rd_word : '0;
        end else if (word == ID_WORD) begin
          out_item_nxt.read_data = ID_VALUE;
        end else begin
          out_item_nxt.read_data = gen_r[gen_idx];
        end
      end
      OP_WRITE, OP_TICK: begin
        for (int c = 0; c < MAX_CHAN; c++) begin
          out_item_nxt.done_irq_mask[c] = rsp[c].done;
          out_item_nxt.error_irq   = out_item_nxt.error_irq | rsp[c].err;
          out_item_nxt.xfer_valid  = out_item_nxt.xfer_valid | rsp[c].xfer_valid;
          out_item_nxt.xfer_source = out_item_nxt.xfer_source | rsp[c].src;
          out_item_nxt.xfer_target = out_item_nxt.xfer_target | rsp[c].dst;
          out_item_nxt.xfer_length = out_item_nxt.xfer_length | rsp[c].len;
        end
      end
      default: out_item_nxt = '0;
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = move ? fire : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GEN_WORDS; i++) begin
        gen_r[i] <= '0;
      end
    end else if (gen_wr) begin
      gen_r[gen_idx] <= s1_item_r.write_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("item in flight did not reach the result register");

  a_err_xfer_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.error_irq && out_item_r.xfer_valid))
    else $error("start both refused and issued");

  a_xfer_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.xfer_valid) |->
      (out_item_r.xfer_length != '0) && (out_item_r.read_data == '0))
    else $error("issued transfer with zero length or read data");

  a_done_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_item_r.done_irq_mask >> CHANNELS) == '0))
    else $error("done raised for a missing channel");

endmodule
